[design/ecis_pkg.sv]
`default_nettype none
package ecis_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int MEM_AW = $clog2(MEM_DEPTH);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_HALTED = 2'd2;

  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_CLEAR = 4'd1;
  localparam logic [3:0] CMD_LOAD = 4'd2;
  localparam logic [3:0] CMD_IDLE_STEP = 4'd3;
  localparam logic [3:0] CMD_FETCH = 4'd4;
  localparam logic [3:0] CMD_OP = 4'd5;
  localparam logic [3:0] CMD_HALT = 4'd6;
  localparam logic [3:0] CMD_IMM_RD = 4'd7;
  localparam logic [3:0] CMD_IMM_TAKE = 4'd8;
  localparam logic [3:0] CMD_MEM_ISSUE = 4'd9;
  localparam logic [3:0] CMD_MEM_TAKE = 4'd10;
  localparam logic [3:0] CMD_EXEC = 4'd11;

  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_LXI_B = 8'h01;
  localparam logic [7:0] OP_DCR_B = 8'h05;
  localparam logic [7:0] OP_MVI_B = 8'h06;
  localparam logic [7:0] OP_DAD_B = 8'h09;
  localparam logic [7:0] OP_DCR_C = 8'h0D;
  localparam logic [7:0] OP_MVI_C = 8'h0E;
  localparam logic [7:0] OP_RRC = 8'h0F;
  localparam logic [7:0] OP_LXI_D = 8'h11;
  localparam logic [7:0] OP_INX_D = 8'h13;
  localparam logic [7:0] OP_DAD_D = 8'h19;
  localparam logic [7:0] OP_LDAX_D = 8'h1A;
  localparam logic [7:0] OP_LXI_H = 8'h21;
  localparam logic [7:0] OP_INX_H = 8'h23;
  localparam logic [7:0] OP_MVI_H = 8'h26;
  localparam logic [7:0] OP_DAD_H = 8'h29;
  localparam logic [7:0] OP_LXI_SP = 8'h31;
  localparam logic [7:0] OP_STA = 8'h32;
  localparam logic [7:0] OP_MVI_M = 8'h36;
  localparam logic [7:0] OP_LDA = 8'h3A;
  localparam logic [7:0] OP_MVI_A = 8'h3E;
  localparam logic [7:0] OP_MOV_DM = 8'h56;
  localparam logic [7:0] OP_MOV_EM = 8'h5E;
  localparam logic [7:0] OP_MOV_HM = 8'h66;
  localparam logic [7:0] OP_MOV_LA = 8'h6F;
  localparam logic [7:0] OP_MOV_MA = 8'h77;
  localparam logic [7:0] OP_MOV_AD = 8'h7A;
  localparam logic [7:0] OP_MOV_AE = 8'h7B;
  localparam logic [7:0] OP_MOV_AH = 8'h7C;
  localparam logic [7:0] OP_MOV_AM = 8'h7E;
  localparam logic [7:0] OP_ANA_A = 8'hA7;
  localparam logic [7:0] OP_XRA_A = 8'hAF;
  localparam logic [7:0] OP_POP_B = 8'hC1;
  localparam logic [7:0] OP_JNZ = 8'hC2;
  localparam logic [7:0] OP_JMP = 8'hC3;
  localparam logic [7:0] OP_PUSH_B = 8'hC5;
  localparam logic [7:0] OP_ADI = 8'hC6;
  localparam logic [7:0] OP_RET = 8'hC9;
  localparam logic [7:0] OP_CALL = 8'hCD;
  localparam logic [7:0] OP_POP_D = 8'hD1;
  localparam logic [7:0] OP_OUT = 8'hD3;
  localparam logic [7:0] OP_PUSH_D = 8'hD5;
  localparam logic [7:0] OP_POP_H = 8'hE1;
  localparam logic [7:0] OP_PUSH_H = 8'hE5;
  localparam logic [7:0] OP_ANI = 8'hE6;
  localparam logic [7:0] OP_XCHG = 8'hEB;
  localparam logic [7:0] OP_POP_PSW = 8'hF1;
  localparam logic [7:0] OP_PUSH_PSW = 8'hF5;
  localparam logic [7:0] OP_EI = 8'hFB;
  localparam logic [7:0] OP_CPI = 8'hFE;

  typedef struct packed {
    logic [3:0] code;
    logic       sel;
  } cmd_t;

  typedef struct packed {
    logic       halted;
    logic       clr_done;
    logic       ok;
    logic [1:0] imm;
    logic [1:0] acc;
  } sta_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] imm;
    logic [1:0] acc;
  } dec_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d = '{ok: 1'b1, imm: 2'd0, acc: 2'd0};
    unique case (op)
      OP_LXI_B, OP_LXI_D, OP_LXI_H, OP_LXI_SP, OP_JNZ, OP_JMP: d.imm = 2'd2;
      OP_MVI_B, OP_MVI_C, OP_MVI_H, OP_MVI_A, OP_ANI, OP_ADI, OP_CPI, OP_OUT: d.imm = 2'd1;
      OP_STA, OP_LDA: begin
        d.imm = 2'd2;
        d.acc = 2'd1;
      end
      OP_MVI_M: begin
        d.imm = 2'd1;
        d.acc = 2'd1;
      end
      OP_CALL: begin
        d.imm = 2'd2;
        d.acc = 2'd2;
      end
      OP_LDAX_D, OP_MOV_DM, OP_MOV_EM, OP_MOV_HM, OP_MOV_AM, OP_MOV_MA: d.acc = 2'd1;
      OP_POP_B, OP_POP_D, OP_POP_H, OP_POP_PSW, OP_RET,
      OP_PUSH_B, OP_PUSH_D, OP_PUSH_H, OP_PUSH_PSW: d.acc = 2'd2;
      OP_NOP, OP_EI, OP_DCR_B, OP_DCR_C, OP_DAD_B, OP_DAD_D, OP_DAD_H, OP_RRC,
      OP_INX_D, OP_INX_H, OP_MOV_LA, OP_MOV_AD, OP_MOV_AE, OP_MOV_AH,
      OP_ANA_A, OP_XRA_A, OP_XCHG: d.ok = 1'b1;
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[design/ecis_req_if.sv]
`default_nettype none
interface ecis_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] load_addr;
  logic [7:0]  load_data;

  modport source(output valid, req_type, load_addr, load_data, input ready);
  modport sink(input valid, req_type, load_addr, load_data, output ready);
endinterface
`default_nettype wire

[design/ecis_rsp_if.sv]
`default_nettype none
interface ecis_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  executed_opcode;
  logic [15:0] pc_out;
  logic [15:0] sp_out;
  logic [7:0]  acc_out;
  logic [15:0] bc_out;
  logic [15:0] de_out;
  logic [15:0] hl_out;
  logic [4:0]  flags_out;

  modport source(output valid, status, executed_opcode, pc_out, sp_out, acc_out,
                 bc_out, de_out, hl_out, flags_out, input ready);
  modport sink(input valid, status, executed_opcode, pc_out, sp_out, acc_out,
               bc_out, de_out, hl_out, flags_out, output ready);
endinterface
`default_nettype wire

[design/ecis_datapath.sv]
`default_nettype none
module ecis_datapath (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ecis_pkg::cmd_t cmd,
  input  wire logic [15:0] load_addr,
  input  wire logic [7:0]  load_data,
  output ecis_pkg::sta_t   sta,
  output logic [7:0]       op,
  output logic [15:0]      pc,
  output logic [15:0]      sp,
  output logic [7:0]       acc,
  output logic [15:0]      bc,
  output logic [15:0]      de,
  output logic [15:0]      hl,
  output logic [4:0]       flags
);
  import ecis_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rdata;
  logic              halted;
  logic [MEM_AW-1:0] clr;
  logic [15:0]       tmp;
  logic [15:0]       md;

  logic              mem_we;
  logic [15:0]       mem_addr;
  logic [MEM_AW-1:0] mem_idx;
  logic [7:0]        mem_wd;
  dec_t              dec;

  logic [7:0]  b_dec, c_dec;
  logic [16:0] dad_sum;
  logic [15:0] dad_arg;
  logic [7:0]  and_val;
  logic [8:0]  add_val;
  logic [8:0]  sub_val;
  logic [15:0] push_val;

  function automatic logic [4:0] szp(input logic [4:0] f, input logic [7:0] v,
                                     input logic c);
    return {f[4], c, ~^v, v[7], v == 8'h00};
  endfunction

  assign dec = decode(op);
  assign sta = '{halted: halted, clr_done: &clr, ok: dec.ok, imm: dec.imm, acc: dec.acc};

  always_comb begin
    b_dec = bc[15:8] - 8'd1;
    c_dec = bc[7:0] - 8'd1;
    unique case (op)
      OP_DAD_B: dad_arg = bc;
      OP_DAD_D: dad_arg = de;
      default:  dad_arg = hl;
    endcase
    dad_sum = {1'b0, hl} + {1'b0, dad_arg};
    and_val = acc & tmp[7:0];
    add_val = {1'b0, acc} + {1'b0, tmp[7:0]};
    sub_val = {1'b0, acc} - {1'b0, tmp[7:0]};
    unique case (op)
      OP_PUSH_B:   push_val = bc;
      OP_PUSH_D:   push_val = de;
      OP_PUSH_H:   push_val = hl;
      OP_PUSH_PSW: push_val = {acc, 3'b000, flags};
      default:     push_val = pc;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_addr = pc;
    mem_wd = 8'h00;
    unique case (cmd.code)
      CMD_LOAD: begin
        mem_we = 1'b1;
        mem_addr = load_addr;
        mem_wd = load_data;
      end
      CMD_MEM_ISSUE: begin
        unique case (op)
          OP_LDAX_D: mem_addr = de;
          OP_LDA:    mem_addr = tmp;
          OP_STA: begin
            mem_we = 1'b1;
            mem_addr = tmp;
            mem_wd = acc;
          end
          OP_MVI_M: begin
            mem_we = 1'b1;
            mem_addr = hl;
            mem_wd = tmp[7:0];
          end
          OP_MOV_MA: begin
            mem_we = 1'b1;
            mem_addr = hl;
            mem_wd = acc;
          end
          OP_PUSH_B, OP_PUSH_D, OP_PUSH_H, OP_PUSH_PSW, OP_CALL: begin
            mem_we = 1'b1;
            mem_addr = cmd.sel ? sp - 16'd2 : sp - 16'd1;
            mem_wd = cmd.sel ? push_val[7:0] : push_val[15:8];
          end
          OP_POP_B, OP_POP_D, OP_POP_H, OP_POP_PSW, OP_RET:
            mem_addr = cmd.sel ? sp + 16'd1 : sp;
          default: mem_addr = hl;
        endcase
      end
      default: mem_addr = pc;
    endcase
    mem_idx = (cmd.code == CMD_CLEAR) ? clr : mem_addr[MEM_AW-1:0];
    if (cmd.code == CMD_CLEAR) begin
      mem_we = 1'b1;
      mem_wd = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wd;
    end
    rdata <= mem[mem_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
      clr <= '0;
      pc <= '0;
      sp <= '0;
      acc <= '0;
      bc <= '0;
      de <= '0;
      hl <= '0;
      flags <= '0;
      op <= '0;
    end else begin
      unique case (cmd.code)
        CMD_CLEAR: clr <= clr + 1'b1;
        CMD_LOAD, CMD_IDLE_STEP: op <= 8'h00;
        CMD_FETCH, CMD_IMM_RD: pc <= pc + 16'd1;
        CMD_OP: op <= rdata;
        CMD_HALT: begin
          pc <= pc - 16'd1;
          halted <= 1'b1;
        end
        CMD_IMM_TAKE: begin
          if (cmd.sel) begin
            tmp[15:8] <= rdata;
          end else begin
            tmp[7:0] <= rdata;
          end
        end
        CMD_MEM_TAKE: begin
          if (cmd.sel) begin
            md[15:8] <= rdata;
          end else begin
            md[7:0] <= rdata;
          end
        end
        CMD_EXEC: begin
          unique case (op)
            OP_LXI_B: bc <= tmp;
            OP_LXI_D: de <= tmp;
            OP_LXI_H: hl <= tmp;
            OP_LXI_SP: sp <= tmp;
            OP_DCR_B: begin
              bc[15:8] <= b_dec;
              flags <= szp(flags, b_dec, flags[3]);
            end
            OP_DCR_C: begin
              bc[7:0] <= c_dec;
              flags <= szp(flags, c_dec, flags[3]);
            end
            OP_MVI_B: bc[15:8] <= tmp[7:0];
            OP_MVI_C: bc[7:0] <= tmp[7:0];
            OP_MVI_H: hl[15:8] <= tmp[7:0];
            OP_MVI_A: acc <= tmp[7:0];
            OP_DAD_B, OP_DAD_D, OP_DAD_H: begin
              hl <= dad_sum[15:0];
              flags[3] <= dad_sum[16];
            end
            OP_RRC: begin
              acc <= {acc[0], acc[7:1]};
              flags[3] <= acc[0];
            end
            OP_INX_D: de <= de + 16'd1;
            OP_INX_H: hl <= hl + 16'd1;
            OP_LDAX_D, OP_LDA, OP_MOV_AM: acc <= md[7:0];
            OP_MOV_DM: de[15:8] <= md[7:0];
            OP_MOV_EM: de[7:0] <= md[7:0];
            OP_MOV_HM: hl[15:8] <= md[7:0];
            OP_MOV_LA: hl[7:0] <= acc;
            OP_MOV_AD: acc <= de[15:8];
            OP_MOV_AE: acc <= de[7:0];
            OP_MOV_AH: acc <= hl[15:8];
            OP_ANA_A: flags <= szp(flags, acc, 1'b0);
            OP_XRA_A: begin
              acc <= 8'h00;
              flags <= szp(flags, 8'h00, 1'b0);
            end
            OP_ANI: begin
              acc <= and_val;
              flags <= szp(flags, and_val, 1'b0);
            end
            OP_ADI: begin
              acc <= add_val[7:0];
              flags <= szp(flags, add_val[7:0], add_val[8]);
            end
            OP_CPI: flags <= szp(flags, sub_val[7:0], sub_val[8]);
            OP_POP_B: begin
              bc <= md;
              sp <= sp + 16'd2;
            end
            OP_POP_D: begin
              de <= md;
              sp <= sp + 16'd2;
            end
            OP_POP_H: begin
              hl <= md;
              sp <= sp + 16'd2;
            end
            OP_POP_PSW: begin
              acc <= md[15:8];
              flags <= md[4:0];
              sp <= sp + 16'd2;
            end
            OP_RET: begin
              pc <= md;
              sp <= sp + 16'd2;
            end
            OP_PUSH_B, OP_PUSH_D, OP_PUSH_H, OP_PUSH_PSW: sp <= sp - 16'd2;
            OP_CALL: begin
              pc <= tmp;
              sp <= sp - 16'd2;
            end
            OP_JMP: pc <= tmp;
            OP_JNZ: begin
              if (!flags[0]) begin
                pc <= tmp;
              end
            end
            OP_XCHG: begin
              de <= hl;
              hl <= de;
            end
            default: pc <= pc;
          endcase
        end
        default: pc <= pc;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/ecis_ctrl.sv]
`default_nettype none
module ecis_ctrl (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_type,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [1:0]     status,
  input  wire ecis_pkg::sta_t sta,
  output ecis_pkg::cmd_t cmd
);
  import ecis_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_OP = 4'd2;
  localparam logic [3:0] S_DEC = 4'd3;
  localparam logic [3:0] S_IMM = 4'd4;
  localparam logic [3:0] S_IMMD = 4'd5;
  localparam logic [3:0] S_MEM = 4'd6;
  localparam logic [3:0] S_MEMD = 4'd7;
  localparam logic [3:0] S_EXEC = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  logic [3:0] state, state_next;
  logic       sel, sel_next;
  logic [1:0] status_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_RESP);

  always_comb begin
    state_next = state;
    sel_next = sel;
    status_next = status;
    cmd = '{code: CMD_NONE, sel: sel};
    unique case (state)
      S_CLEAR: begin
        cmd.code = CMD_CLEAR;
        if (sta.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RESP;
          status_next = ST_OK;
          if (!in_type) begin
            cmd.code = CMD_LOAD;
          end else if (sta.halted) begin
            cmd.code = CMD_IDLE_STEP;
            status_next = ST_HALTED;
          end else begin
            cmd.code = CMD_FETCH;
            state_next = S_OP;
          end
        end
      end
      S_OP: begin
        cmd.code = CMD_OP;
        state_next = S_DEC;
      end
      S_DEC: begin
        sel_next = 1'b0;
        if (!sta.ok) begin
          cmd.code = CMD_HALT;
          status_next = ST_HALT;
          state_next = S_RESP;
        end else if (sta.imm != 2'd0) begin
          state_next = S_IMM;
        end else if (sta.acc != 2'd0) begin
          state_next = S_MEM;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_IMM: begin
        cmd.code = CMD_IMM_RD;
        state_next = S_IMMD;
      end
      S_IMMD: begin
        cmd.code = CMD_IMM_TAKE;
        if (!sel && sta.imm == 2'd2) begin
          sel_next = 1'b1;
          state_next = S_IMM;
        end else begin
          sel_next = 1'b0;
          state_next = (sta.acc != 2'd0) ? S_MEM : S_EXEC;
        end
      end
      S_MEM: begin
        cmd.code = CMD_MEM_ISSUE;
        state_next = S_MEMD;
      end
      S_MEMD: begin
        cmd.code = CMD_MEM_TAKE;
        if (!sel && sta.acc == 2'd2) begin
          sel_next = 1'b1;
          state_next = S_MEM;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.code = CMD_EXEC;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sel <= 1'b0;
      status <= ST_OK;
    end else begin
      state <= state_next;
      sel <= sel_next;
      status <= status_next;
    end
  end

endmodule
`default_nettype wire

[design/eight_bit_cpu_instruction_step.sv]
`default_nettype none
// channel | dir | payload
// req     | in  | req_type, load_addr, load_data
// rsp     | out | status, executed_opcode, pc/sp/acc/bc/de/hl/flags
//
// after reset a clearing pass zeroes all 65536 bytes of memory, one byte a cycle
// a load or a halted step goes from idle straight to the response state
// a step runs fetch, decode, a read and a take per operand byte and per
// data or stack access on the single memory port, then execute; an
// unsupported opcode halts at decode and goes straight to the response state
// one word at a time; a stalled rsp holds the block with req ready low
module eight_bit_cpu_instruction_step (
  input wire logic   clk,
  input wire logic   rst,
  ecis_req_if.sink   req,
  ecis_rsp_if.source rsp
);
  import ecis_pkg::*;

  cmd_t cmd;
  sta_t sta;

  ecis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_type   (req.req_type),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .sta       (sta),
    .cmd       (cmd)
  );

  ecis_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .load_addr (req.load_addr),
    .load_data (req.load_data),
    .sta       (sta),
    .op        (rsp.executed_opcode),
    .pc        (rsp.pc_out),
    .sp        (rsp.sp_out),
    .acc       (rsp.acc_out),
    .bc        (rsp.bc_out),
    .de        (rsp.de_out),
    .hl        (rsp.hl_out),
    .flags     (rsp.flags_out)
  );

endmodule
`default_nettype wire

[design/ecis_chk.sv]
`default_nettype none
module ecis_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic [7:0] opcode
);
  import ecis_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while word pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_HALT || status == ST_HALTED))
    else $error("bad status");

  a_halted_opcode: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_HALTED |-> opcode == 8'h00)
    else $error("opcode on refused step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(opcode))
    else $error("word dropped");

endmodule

bind eight_bit_cpu_instruction_step ecis_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .status    (rsp.status),
  .opcode    (rsp.executed_opcode)
);
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import ecis_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  ecis_req_if req ();
  ecis_rsp_if rsp ();

  eight_bit_cpu_instruction_step dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  opcode;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [7:0]  acc;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [4:0]  flags;
  } cpu_view_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;
  localparam logic [4:0] FL_Z = 5'h01;
  localparam logic [4:0] FL_S = 5'h02;
  localparam logic [4:0] FL_P = 5'h04;
  localparam logic [4:0] FL_C = 5'h08;
  localparam logic [4:0] FL_AC = 5'h10;

  logic [7:0]  mem_model [0:65535];
  logic [15:0] pc_m, sp_m;
  logic [7:0]  a_m, b_m, c_m, d_m, e_m, h_m, l_m;
  logic [4:0]  f_m;
  logic        halt_m;

  cpu_view_t   expected_views [$];
  int          errors = 0;
  int          cycle = 0;
  bit          idle_en = 1'b1;
  bit          hold_off = 1'b0;

  logic [7:0] supported [$] = '{OP_NOP, OP_LXI_B, OP_DCR_B, OP_MVI_B, OP_DAD_B, OP_DCR_C,
    OP_MVI_C, OP_RRC, OP_LXI_D, OP_INX_D, OP_DAD_D, OP_LDAX_D, OP_LXI_H, OP_INX_H,
    OP_MVI_H, OP_DAD_H, OP_LXI_SP, OP_STA, OP_MVI_M, OP_LDA, OP_MVI_A, OP_MOV_DM,
    OP_MOV_EM, OP_MOV_HM, OP_MOV_LA, OP_MOV_AM, OP_MOV_MA, OP_MOV_AD, OP_MOV_AE,
    OP_MOV_AH, OP_ANA_A, OP_XRA_A, OP_POP_B, OP_JNZ, OP_JMP, OP_PUSH_B, OP_ADI,
    OP_RET, OP_CALL, OP_POP_D, OP_OUT, OP_PUSH_D, OP_POP_H, OP_PUSH_H, OP_ANI,
    OP_XCHG, OP_POP_PSW, OP_PUSH_PSW, OP_EI, OP_CPI};

  function automatic logic [7:0] rd8(logic [15:0] a);
    return mem_model[a];
  endfunction

  function automatic logic [7:0] next_byte();
    logic [7:0] v;
    v = mem_model[pc_m];
    pc_m = pc_m + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] next_word();
    logic [7:0] lo;
    lo = next_byte();
    return {next_byte(), lo};
  endfunction

  function automatic void szp(logic [7:0] v);
    f_m = f_m & (FL_C | FL_AC);
    if (v == 8'd0) f_m |= FL_Z;
    if (v[7]) f_m |= FL_S;
    if (!(^v)) f_m |= FL_P;
  endfunction

  function automatic void carry(logic c);
    f_m = c ? (f_m | FL_C) : (f_m & ~FL_C);
  endfunction

  function automatic void push16(logic [15:0] v);
    mem_model[sp_m - 16'd1] = v[15:8];
    mem_model[sp_m - 16'd2] = v[7:0];
    sp_m = sp_m - 16'd2;
  endfunction

  function automatic logic [15:0] pop16();
    logic [15:0] v;
    v = {mem_model[sp_m + 16'd1], mem_model[sp_m]};
    sp_m = sp_m + 16'd2;
    return v;
  endfunction

  function automatic void dad(logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, h_m, l_m} + {1'b0, v};
    {h_m, l_m} = s[15:0];
    carry(s[16]);
  endfunction

  function automatic bit exec_op(logic [7:0] op);
    logic [15:0] t;
    logic [8:0]  s;
    logic [7:0]  v;
    case (op)
      OP_NOP, OP_EI: ;
      OP_LXI_B: {b_m, c_m} = next_word();
      OP_LXI_D: {d_m, e_m} = next_word();
      OP_LXI_H: {h_m, l_m} = next_word();
      OP_LXI_SP: sp_m = next_word();
      OP_DCR_B: begin b_m = b_m - 8'd1; szp(b_m); end
      OP_DCR_C: begin c_m = c_m - 8'd1; szp(c_m); end
      OP_MVI_B: b_m = next_byte();
      OP_MVI_C: c_m = next_byte();
      OP_MVI_H: h_m = next_byte();
      OP_MVI_A: a_m = next_byte();
      OP_MVI_M: begin v = next_byte(); mem_model[{h_m, l_m}] = v; end
      OP_DAD_B: dad({b_m, c_m});
      OP_DAD_D: dad({d_m, e_m});
      OP_DAD_H: dad({h_m, l_m});
      OP_RRC: begin carry(a_m[0]); a_m = {a_m[0], a_m[7:1]}; end
      OP_INX_D: {d_m, e_m} = {d_m, e_m} + 16'd1;
      OP_INX_H: {h_m, l_m} = {h_m, l_m} + 16'd1;
      OP_LDAX_D: a_m = rd8({d_m, e_m});
      OP_STA: begin t = next_word(); mem_model[t] = a_m; end
      OP_LDA: begin t = next_word(); a_m = rd8(t); end
      OP_MOV_DM: d_m = rd8({h_m, l_m});
      OP_MOV_EM: e_m = rd8({h_m, l_m});
      OP_MOV_HM: h_m = rd8({h_m, l_m});
      OP_MOV_LA: l_m = a_m;
      OP_MOV_MA: mem_model[{h_m, l_m}] = a_m;
      OP_MOV_AD: a_m = d_m;
      OP_MOV_AE: a_m = e_m;
      OP_MOV_AH: a_m = h_m;
      OP_MOV_AM: a_m = rd8({h_m, l_m});
      OP_ANA_A: begin szp(a_m); carry(1'b0); end
      OP_XRA_A: begin a_m = 8'd0; szp(a_m); carry(1'b0); end
      OP_ANI: begin a_m = a_m & next_byte(); szp(a_m); carry(1'b0); end
      OP_ADI: begin
        s = {1'b0, a_m} + {1'b0, next_byte()};
        a_m = s[7:0]; szp(a_m); carry(s[8]);
      end
      OP_CPI: begin v = next_byte(); szp(a_m - v); carry(a_m < v); end
      OP_POP_B: {b_m, c_m} = pop16();
      OP_POP_D: {d_m, e_m} = pop16();
      OP_POP_H: {h_m, l_m} = pop16();
      OP_POP_PSW: begin t = pop16(); a_m = t[15:8]; f_m = t[4:0]; end
      OP_PUSH_B: push16({b_m, c_m});
      OP_PUSH_D: push16({d_m, e_m});
      OP_PUSH_H: push16({h_m, l_m});
      OP_PUSH_PSW: push16({a_m, 3'b000, f_m});
      OP_JNZ: begin t = next_word(); if (!f_m[0]) pc_m = t; end
      OP_JMP: pc_m = next_word();
      OP_RET: pc_m = pop16();
      OP_CALL: begin t = next_word(); push16(pc_m); pc_m = t; end
      OP_OUT: v = next_byte();
      OP_XCHG: begin {d_m, e_m, h_m, l_m} = {h_m, l_m, d_m, e_m}; end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic cpu_view_t predict_view(logic kind, logic [15:0] addr,
                                             logic [7:0] data);
    cpu_view_t r;
    logic [15:0] start;
    logic [7:0] op;
    r.status = ST_OK;
    op = 8'd0;
    if (kind == REQ_LOAD) begin
      mem_model[addr] = data;
    end else if (halt_m) begin
      r.status = ST_HALTED;
    end else begin
      start = pc_m;
      op = next_byte();
      if (!exec_op(op)) begin
        pc_m = start;
        halt_m = 1'b1;
        r.status = ST_HALT;
      end
    end
    r.opcode = op;
    r.pc = pc_m;
    r.sp = sp_m;
    r.acc = a_m;
    r.bc = {b_m, c_m};
    r.de = {d_m, e_m};
    r.hl = {h_m, l_m};
    r.flags = f_m;
    return r;
  endfunction

  task automatic send_word(logic kind, logic [15:0] addr, logic [7:0] data);
    while (idle_en && $urandom_range(0, 99) < 25) begin
      req.valid <= 1'b0;
      req.req_type <= 1'($urandom);
      req.load_addr <= 16'($urandom);
      req.load_data <= 8'($urandom);
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.load_addr <= addr;
    req.load_data <= data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_views.push_back(predict_view(kind, addr, data));
    @(negedge clk);
  endtask

  task automatic load_bytes(logic [15:0] addr, logic [7:0] bytes [$]);
    foreach (bytes[i]) send_word(REQ_LOAD, addr + 16'(i), bytes[i]);
  endtask

  task automatic step_cpu(int n);
    repeat (n) send_word(REQ_STEP, 16'd0, 8'd0);
  endtask

  task automatic wait_drained();
    while (expected_views.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_off) rsp.ready <= 1'b0;
    else if (!idle_en) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    cpu_view_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.status, rsp.executed_opcode, rsp.pc_out, rsp.sp_out, rsp.acc_out,
              rsp.bc_out, rsp.de_out, rsp.hl_out, rsp.flags_out};
      if (expected_views.size() == 0) begin
        errors++;
        $display("%0t unexpected word: actual %h", $time, got);
      end else begin
        want = expected_views.pop_front();
        if (got.status !== want.status)
          $display("%0t status expected %h actual %h", $time, want.status, got.status);
        if (got.opcode !== want.opcode)
          $display("%0t opcode expected %h actual %h", $time, want.opcode, got.opcode);
        if (got.pc !== want.pc)
          $display("%0t pc expected %h actual %h", $time, want.pc, got.pc);
        if (got.sp !== want.sp)
          $display("%0t sp expected %h actual %h", $time, want.sp, got.sp);
        if (got.acc !== want.acc)
          $display("%0t acc expected %h actual %h", $time, want.acc, got.acc);
        if (got.bc !== want.bc)
          $display("%0t bc expected %h actual %h", $time, want.bc, got.bc);
        if (got.de !== want.de)
          $display("%0t de expected %h actual %h", $time, want.de, got.de);
        if (got.hl !== want.hl)
          $display("%0t hl expected %h actual %h", $time, want.hl, got.hl);
        if (got.flags !== want.flags)
          $display("%0t flags expected %h actual %h", $time, want.flags, got.flags);
        if (got !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 1500000) begin
      $display("eight_bit_cpu_instruction_step test failed");
      $finish;
    end
  end

  // directed program touching a set of the opcodes and the flag corners
  task automatic test_directed();
    load_bytes(16'h0000, '{OP_LXI_SP, 8'h00, 8'h00, OP_MVI_A, 8'hFF, OP_ADI, 8'h01,
      OP_CPI, 8'h01, OP_MVI_B, 8'h01, OP_DCR_B, OP_DCR_B, OP_LXI_H, 8'hFF, 8'hFF,
      OP_DAD_H, OP_PUSH_PSW, OP_POP_PSW, OP_CALL, 8'h40, 8'h00, OP_JMP, 8'hFF, 8'hFF});
    load_bytes(16'h0040, '{OP_RRC, OP_XRA_A, OP_RET});
    load_bytes(16'hFFFF, '{OP_MVI_C});
    step_cpu(16);
    // pc wraps to operand at 0000
    step_cpu(1);
    load_bytes(16'h0200, '{8'h08});
    step_cpu(2);
  endtask

  // random programs of supported opcodes with random operands
  task automatic test_random_programs(int words);
    int sent;
    logic [15:0] base;
    logic [7:0] prog [$];
    sent = 0;
    while (sent < words) begin
      base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
      prog.delete();
      repeat ($urandom_range(4, 20)) begin
        prog.push_back(supported[$urandom_range(0, supported.size() - 1)]);
        if ($urandom_range(0, 9) == 0) prog.push_back(8'($urandom));
      end
      load_bytes(base, prog);
      load_bytes(16'h0000, '{OP_JMP, base[7:0], base[15:8]});
      sent += prog.size() + 3;
      send_word(REQ_STEP, 16'd0, 8'd0);
      send_word(REQ_STEP, 16'd0, 8'd0);
      step_cpu(prog.size() + 4);
      sent += prog.size() + 6;
    end
  endtask

  // output stalls long enough for the input to back up
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      step_cpu(20);
    join
  endtask

  task automatic test_halt();
    load_bytes(pc_m, '{8'h76});
    step_cpu(3);
    send_word(REQ_LOAD, 16'h1234, 8'h5A);
    step_cpu(1);
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) mem_model[i] = 8'd0;
    {pc_m, sp_m, a_m, b_m, c_m, d_m, e_m, h_m, l_m, f_m, halt_m} = '0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.load_addr = 16'd0;
    req.load_data = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    idle_en = 1'b0;
    test_random_programs(200);
    idle_en = 1'b1;
    test_backpressure();
    test_random_programs(600);
    test_halt();
    req.valid <= 1'b0;
    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0) $display("eight_bit_cpu_instruction_step test passed");
    else $display("eight_bit_cpu_instruction_step test failed");
    $finish;
  end

endmodule
